@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the k-mer set builder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property checked on every clock edge outside reset
`define KMSB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// property checked on every clock edge, reset included
`define KMSB_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KMSB_ASSERT(lbl, prop, msg)
`define KMSB_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ rtl/core/kmsb_pkg.sv @@
// shared types, constants and codes for the k-mer set builder
package kmsb_pkg;

	// default sizes
	localparam int unsigned MAX_K_DEF    = 16;
	localparam int unsigned CAPACITY_DEF = 4096;

	// port widths
	localparam int unsigned KEY_PORT_W = 48;
	localparam int unsigned BASE_W     = 3;
	localparam int unsigned KLEN_W     = 5;
	localparam int unsigned SMASK_W    = 4;
	localparam int unsigned PADDR_W    = 3;
	localparam int unsigned PDATA_W    = 32;

	// register map (word index taken from paddr above the byte offset)
	localparam logic REG_K_LEN = 1'b0;
	localparam logic [KLEN_W-1:0] K_LEN_RESET = 5'd16;

	// word codes
	localparam logic FUNC_PUSH  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam logic [BASE_W-1:0] BASE_C = 3'd1;
	localparam logic [BASE_W-1:0] BASE_G = 3'd2;
	localparam logic [BASE_W-1:0] BASE_S = 3'd4;

	// golden-ratio multiplier of the slot hash, split in halves
	localparam logic [31:0] HASH_MUL_LO = 32'h7F4A7C15;
	localparam logic [31:0] HASH_MUL_HI = 32'h9E3779B9;

	// main sequencer
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXPAND,
		ST_NEXT,
		ST_HASH,
		ST_READ,
		ST_CHECK
	} state_t;

	// hash unit steps; LO, MID0, MID1, RECIP and BACK use one multiply each
	typedef enum logic [2:0] {
		HS_IDLE,
		HS_LO,
		HS_MID0,
		HS_MID1,
		HS_RECIP,
		HS_BACK,
		HS_FIX
	} hstep_t;

endpackage

@@ rtl/core/kmsb_hash.sv @@
// multi-cycle slot hash: high word of key times golden ratio, modulo capacity
module kmsb_hash #(
	parameter int unsigned KEY_W    = 3 * kmsb_pkg::MAX_K_DEF,
	parameter int unsigned CAPACITY = kmsb_pkg::CAPACITY_DEF,
	parameter int unsigned ADDR_W   = $clog2(CAPACITY)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [KEY_W-1:0]  key,
	output logic              done,
	output logic [ADDR_W-1:0] slot
);

	// floor(2^32 / capacity) for the reciprocal divide
	localparam longint unsigned RECIP_FULL = (64'd1 << 32) / CAPACITY;
	localparam logic [31:0] RECIP = 32'(RECIP_FULL);
	localparam logic [31:0] CAP32 = 32'(CAPACITY);

	kmsb_pkg::hstep_t step_q, step_d;

	logic [63:0] key64_q;
	logic [31:0] h_q;
	logic [31:0] q_q;
	logic [31:0] r_q;
	logic [31:0] a_op;
	logic [31:0] b_op;
	logic [63:0] prod;
	logic        done_q;
	logic [ADDR_W-1:0] slot_q;

	// step register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= kmsb_pkg::HS_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	// step sequence and multiplier operand select
	always_comb begin
		step_d = step_q;
		a_op   = '0;
		b_op   = '0;
		unique case (step_q)
			kmsb_pkg::HS_IDLE: begin
				if (start) begin
					step_d = kmsb_pkg::HS_LO;
				end
			end
			kmsb_pkg::HS_LO: begin
				a_op   = key64_q[31:0];
				b_op   = kmsb_pkg::HASH_MUL_LO;
				step_d = kmsb_pkg::HS_MID0;
			end
			kmsb_pkg::HS_MID0: begin
				a_op   = key64_q[31:0];
				b_op   = kmsb_pkg::HASH_MUL_HI;
				step_d = kmsb_pkg::HS_MID1;
			end
			kmsb_pkg::HS_MID1: begin
				a_op   = key64_q[63:32];
				b_op   = kmsb_pkg::HASH_MUL_LO;
				step_d = kmsb_pkg::HS_RECIP;
			end
			kmsb_pkg::HS_RECIP: begin
				a_op   = h_q;
				b_op   = RECIP;
				step_d = kmsb_pkg::HS_BACK;
			end
			kmsb_pkg::HS_BACK: begin
				a_op   = q_q;
				b_op   = CAP32;
				step_d = kmsb_pkg::HS_FIX;
			end
			kmsb_pkg::HS_FIX: begin
				step_d = kmsb_pkg::HS_IDLE;
			end
			default: begin
				step_d = kmsb_pkg::HS_IDLE;
			end
		endcase
	end

	// shared 32x32 multiplier
	assign prod = 64'(a_op) * 64'(b_op);

	// done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (step_q == kmsb_pkg::HS_FIX);
		end
	end

	// hash datapath: bits 63..32 of key*mult, then remainder by capacity
	always_ff @(posedge clk) begin
		case (step_q)
			kmsb_pkg::HS_IDLE: begin
				if (start) begin
					key64_q <= 64'(key);
				end
			end
			kmsb_pkg::HS_LO:    h_q <= prod[63:32];
			kmsb_pkg::HS_MID0:  h_q <= h_q + prod[31:0];
			kmsb_pkg::HS_MID1:  h_q <= h_q + prod[31:0];
			kmsb_pkg::HS_RECIP: q_q <= prod[63:32];
			kmsb_pkg::HS_BACK:  r_q <= h_q - prod[31:0];
			kmsb_pkg::HS_FIX: begin
				// estimate is at most one short, so one subtract corrects it
				if (r_q >= CAP32) begin
					slot_q <= ADDR_W'(r_q - CAP32);
				end else begin
					slot_q <= ADDR_W'(r_q);
				end
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign slot = slot_q;

endmodule

@@ rtl/core/kmer_set_builder_top.sv @@
// k-mer set builder: sliding base window feeding a hashed set of distinct keys
//
// channel   handshake                       payload
// config    psel/penable/pwrite, pready=1   paddr, pwdata, prdata (k_len)
// input     start & !busy                   func, base, read_start, query_key
// result    result_valid (one cycle)        kmer, was_new, table_full,
//                                           successor_mask, last
//
// a push that leaves the window short of k bases stays in idle; busy stays low.
// each table lookup runs the shared-multiplier hash unit and then probes the key
// memory slot by slot; a push with a result makes one lookup, or two when the
// window holds an S, and a query makes up to four, where a candidate equal to the
// key itself is skipped without a lookup.
// after reset busy is held while the memory is swept clear.
// results carry no back pressure; the receiver takes each word as it appears.
`include "assert_macros.svh"

module kmer_set_builder_top #(
	parameter int unsigned MAX_K    = kmsb_pkg::MAX_K_DEF,
	parameter int unsigned CAPACITY = kmsb_pkg::CAPACITY_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [kmsb_pkg::PADDR_W-1:0]        paddr,
	input  logic [kmsb_pkg::PDATA_W-1:0]        pwdata,
	output logic [kmsb_pkg::PDATA_W-1:0]        prdata,
	output logic                                pready,
	// input word
	input  logic                                start,
	output logic                                busy,
	input  logic                                func,
	input  logic [kmsb_pkg::BASE_W-1:0]         base,
	input  logic                                read_start,
	input  logic [kmsb_pkg::KEY_PORT_W-1:0]     query_key,
	// result word
	output logic                                result_valid,
	output logic [kmsb_pkg::KEY_PORT_W-1:0]     kmer,
	output logic                                was_new,
	output logic                                table_full,
	output logic [kmsb_pkg::SMASK_W-1:0]        successor_mask,
	output logic                                last
);

	localparam int unsigned KEY_W  = 3 * MAX_K;
	localparam int unsigned ADDR_W = $clog2(CAPACITY);
	localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
	localparam int unsigned KW     = kmsb_pkg::KLEN_W;

	kmsb_pkg::state_t state_q, state_d;

	// control and datapath registers
	logic [KW-1:0]     k_len_q;
	logic [KEY_W-1:0]  window_q;
	logic [KW-1:0]     fill_q;
	logic [CNT_W-1:0]  count_q;
	logic [ADDR_W-1:0] clear_addr_q;
	logic              func_q;
	logic              two_q;
	logic [1:0]        idx_q;
	logic [3:0]        smask_q;
	logic [ADDR_W-1:0] slot_q;
	logic [ADDR_W-1:0] probe_q;
	logic [KEY_W-1:0]  qkey_q;
	logic [KEY_W-1:0]  key0_q;
	logic [KEY_W-1:0]  key1_q;
	logic [KEY_W-1:0]  cur_key_q;

	// key memory: valid bit on top of the key
	logic [KEY_W:0]    mem [CAPACITY];
	logic [KEY_W:0]    rd_q;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [KEY_W:0]    mem_wdata;

	// result registers
	logic              result_valid_q;
	logic [KEY_W-1:0]  res_key_q;
	logic              res_new_q;
	logic              res_full_q;
	logic [3:0]        res_mask_q;
	logic              res_last_q;

	// combinational
	logic [KW-1:0]     k_eff;
	logic [KEY_W-1:0]  kmask;
	logic              accept;
	logic              cfg_write;
	logic [KEY_W-1:0]  win_base;
	logic [KW-1:0]     fill_base;
	logic [KEY_W-1:0]  win_nx;
	logic [KW-1:0]     fill_nx;
	logic              push_full;
	logic              s_found;
	logic [KW-1:0]     s_pos;
	logic [KEY_W-1:0]  key_g;
	logic [KEY_W-1:0]  key_c;
	logic [KEY_W-1:0]  q_cand;
	logic              q_skip;
	logic [KEY_W-1:0]  next_key;
	logic              rd_valid;
	logic              hit;
	logic              slot_empty;
	logic              exhausted;
	logic              resolved;
	logic              room;
	logic              ins_new;
	logic              more_ins;
	logic [3:0]        mask_upd;
	logic              hash_start;
	logic              hash_done;
	logic [ADDR_W-1:0] hash_slot;
	logic [ADDR_W-1:0] slot_next;
	logic              emit;
	logic [KEY_W-1:0]  emit_key;
	logic              emit_new;
	logic              emit_full;
	logic [3:0]        emit_mask;
	logic              emit_last;

	// effective k-mer length, clamped to 1..MAX_K
	always_comb begin
		k_eff = k_len_q;
		if (k_len_q == '0) begin
			k_eff = KW'(1);
		end else if (k_len_q > KW'(MAX_K)) begin
			k_eff = KW'(MAX_K);
		end
	end

	// key mask of 3*k bits
	always_comb begin
		for (int j = 0; j < int'(KEY_W); j++) begin
			kmask[j] = (j < 3 * int'(k_eff));
		end
	end

	// configuration port
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign prdata    = (paddr[kmsb_pkg::PADDR_W-1:2] == kmsb_pkg::REG_K_LEN) ?
		kmsb_pkg::PDATA_W'(k_len_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_len_q <= kmsb_pkg::K_LEN_RESET;
		end else if (cfg_write && paddr[kmsb_pkg::PADDR_W-1:2] == kmsb_pkg::REG_K_LEN) begin
			k_len_q <= pwdata[KW-1:0];
		end
	end

	// window shift for a pushed base
	assign accept    = start && (state_q == kmsb_pkg::ST_IDLE);
	assign busy      = (state_q != kmsb_pkg::ST_IDLE);
	assign win_base  = read_start ? '0 : window_q;
	assign fill_base = read_start ? '0 : fill_q;
	assign win_nx    = ((win_base << 3) | KEY_W'(base)) & kmask;
	assign fill_nx   = (fill_base < k_eff) ? fill_base + KW'(1) : fill_base;
	assign push_full = (fill_nx >= k_eff);

	// oldest S in the window and its G and C variants
	always_comb begin
		s_found = 1'b0;
		s_pos   = '0;
		for (int j = 0; j < int'(MAX_K); j++) begin
			if (j < int'(k_eff) && window_q[3*j +: 3] == kmsb_pkg::BASE_S) begin
				s_found = 1'b1;
				s_pos   = KW'(j);
			end
		end
		key_g = window_q;
		key_c = window_q;
		for (int j = 0; j < int'(MAX_K); j++) begin
			if (s_found && s_pos == KW'(j)) begin
				key_g[3*j +: 3] = kmsb_pkg::BASE_G;
				key_c[3*j +: 3] = kmsb_pkg::BASE_C;
			end
		end
	end

	// successor candidate of the query key
	assign q_cand = ((qkey_q << 3) & kmask) | KEY_W'(idx_q);
	assign q_skip = (q_cand == qkey_q);

	// key of the next lookup, seen by the hash unit as it starts
	assign next_key = (func_q == kmsb_pkg::FUNC_QUERY) ? q_cand :
		((idx_q == 2'd0) ? key0_q : key1_q);

	// probe result
	assign rd_valid   = rd_q[KEY_W];
	assign hit        = rd_valid && (rd_q[KEY_W-1:0] == cur_key_q);
	assign slot_empty = !rd_valid;
	assign exhausted  = (probe_q == ADDR_W'(CAPACITY - 1));
	assign resolved   = hit || slot_empty || exhausted;
	assign room       = (count_q < CNT_W'(CAPACITY));
	assign ins_new    = slot_empty && room;
	assign more_ins   = two_q && (idx_q == 2'd0);
	assign mask_upd   = smask_q | (hit ? (4'd1 << idx_q) : 4'd0);
	assign slot_next  = (slot_q == ADDR_W'(CAPACITY - 1)) ? '0 : slot_q + ADDR_W'(1);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kmsb_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, memory write, hash start and result words
	always_comb begin
		state_d    = state_q;
		mem_we     = 1'b0;
		mem_waddr  = slot_q;
		mem_wdata  = {1'b1, cur_key_q};
		hash_start = 1'b0;
		emit       = 1'b0;
		emit_key   = cur_key_q;
		emit_new   = 1'b0;
		emit_full  = 1'b0;
		emit_mask  = '0;
		emit_last  = 1'b1;
		unique case (state_q)
			kmsb_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clear_addr_q;
				mem_wdata = '0;
				if (clear_addr_q == ADDR_W'(CAPACITY - 1)) begin
					state_d = kmsb_pkg::ST_IDLE;
				end
			end
			kmsb_pkg::ST_IDLE: begin
				if (accept) begin
					if (func == kmsb_pkg::FUNC_QUERY) begin
						state_d = kmsb_pkg::ST_NEXT;
					end else if (push_full) begin
						state_d = kmsb_pkg::ST_EXPAND;
					end
				end
			end
			kmsb_pkg::ST_EXPAND: begin
				state_d = kmsb_pkg::ST_NEXT;
			end
			kmsb_pkg::ST_NEXT: begin
				if (func_q == kmsb_pkg::FUNC_QUERY && q_skip) begin
					// candidate equal to the key itself is never reported
					if (idx_q == 2'd3) begin
						emit      = 1'b1;
						emit_key  = qkey_q;
						emit_mask = smask_q;
						state_d   = kmsb_pkg::ST_IDLE;
					end
				end else begin
					hash_start = 1'b1;
					state_d    = kmsb_pkg::ST_HASH;
				end
			end
			kmsb_pkg::ST_HASH: begin
				if (hash_done) begin
					state_d = kmsb_pkg::ST_READ;
				end
			end
			kmsb_pkg::ST_READ: begin
				state_d = kmsb_pkg::ST_CHECK;
			end
			kmsb_pkg::ST_CHECK: begin
				if (!resolved) begin
					state_d = kmsb_pkg::ST_READ;
				end else if (func_q == kmsb_pkg::FUNC_QUERY) begin
					if (idx_q == 2'd3) begin
						emit      = 1'b1;
						emit_key  = qkey_q;
						emit_mask = mask_upd;
						state_d   = kmsb_pkg::ST_IDLE;
					end else begin
						state_d = kmsb_pkg::ST_NEXT;
					end
				end else begin
					// insert: claim the empty slot while there is room
					mem_we    = ins_new;
					emit      = 1'b1;
					emit_new  = ins_new;
					emit_full = !hit && !ins_new;
					emit_last = !more_ins;
					state_d   = more_ins ? kmsb_pkg::ST_NEXT : kmsb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = kmsb_pkg::ST_IDLE;
			end
		endcase
	end

	// sequencer control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q     <= '0;
			fill_q       <= '0;
			count_q      <= '0;
			clear_addr_q <= '0;
			func_q       <= kmsb_pkg::FUNC_PUSH;
			two_q        <= 1'b0;
			idx_q        <= '0;
			smask_q      <= '0;
			slot_q       <= '0;
			probe_q      <= '0;
		end else begin
			case (state_q)
				kmsb_pkg::ST_CLEAR: begin
					clear_addr_q <= clear_addr_q + ADDR_W'(1);
				end
				kmsb_pkg::ST_IDLE: begin
					if (accept) begin
						func_q  <= func;
						idx_q   <= '0;
						smask_q <= '0;
						if (func == kmsb_pkg::FUNC_PUSH) begin
							window_q <= win_nx;
							fill_q   <= fill_nx;
						end
					end
				end
				kmsb_pkg::ST_EXPAND: begin
					two_q <= s_found;
				end
				kmsb_pkg::ST_NEXT: begin
					if (func_q == kmsb_pkg::FUNC_QUERY && q_skip && idx_q != 2'd3) begin
						idx_q <= idx_q + 2'd1;
					end
				end
				kmsb_pkg::ST_HASH: begin
					if (hash_done) begin
						slot_q  <= hash_slot;
						probe_q <= '0;
					end
				end
				kmsb_pkg::ST_CHECK: begin
					if (!resolved) begin
						slot_q  <= slot_next;
						probe_q <= probe_q + ADDR_W'(1);
					end else if (func_q == kmsb_pkg::FUNC_QUERY) begin
						smask_q <= mask_upd;
						idx_q   <= idx_q + 2'd1;
					end else begin
						if (ins_new) begin
							count_q <= count_q + CNT_W'(1);
						end
						if (more_ins) begin
							idx_q <= 2'd1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// key registers
	always_ff @(posedge clk) begin
		if (accept && func == kmsb_pkg::FUNC_QUERY) begin
			qkey_q <= KEY_W'(query_key) & kmask;
		end
		if (state_q == kmsb_pkg::ST_EXPAND) begin
			key0_q <= s_found ? key_g : window_q;
			key1_q <= key_c;
		end
		if (state_q == kmsb_pkg::ST_NEXT) begin
			cur_key_q <= next_key;
		end
	end

	// key memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[slot_q];
	end

	// slot hash unit
	kmsb_hash #(
		.KEY_W    (KEY_W),
		.CAPACITY (CAPACITY),
		.ADDR_W   (ADDR_W)
	) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key    (next_key),
		.done   (hash_done),
		.slot   (hash_slot)
	);

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= emit;
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (emit) begin
			res_key_q  <= emit_key;
			res_new_q  <= emit_new;
			res_full_q <= emit_full;
			res_mask_q <= emit_mask;
			res_last_q <= emit_last;
		end
	end

	assign result_valid   = result_valid_q;
	assign kmer           = kmsb_pkg::KEY_PORT_W'(res_key_q);
	assign was_new        = res_new_q;
	assign table_full     = res_full_q;
	assign successor_mask = res_mask_q;
	assign last           = res_last_q;

	// checks
	`KMSB_ASSERT(a_strobe_gap, result_valid_q |=> !result_valid_q, "results in adjacent cycles")
	`KMSB_ASSERT(a_count_bound, count_q <= CNT_W'(CAPACITY), "entry count above capacity")
	`KMSB_ASSERT(a_insert_room, (mem_we && state_q == kmsb_pkg::ST_CHECK) |-> room, "insert into full set")
	`KMSB_ASSERT(a_read_order, (state_q == kmsb_pkg::ST_CHECK) |-> $past(state_q == kmsb_pkg::ST_READ), "probe check without read")

endmodule
